@@ rtl/wavetable_sound_generator_defines.svh @@
// ----------------------------------------------------------------------------
// Wavetable sound generator assertion macros
// Shared assertion helpers; they expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef WAVETABLE_SOUND_GENERATOR_DEFINES_SVH
`define WAVETABLE_SOUND_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define WSG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
// A condition that must never be seen outside reset.
`define WSG_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);
`else
`define WSG_ASSERT(label, prop, msg)
`define WSG_NEVER(label, expr, msg)
`endif
`endif

@@ rtl/wsg_pkg.sv @@
// ----------------------------------------------------------------------------
// Wavetable sound generator package
// Types, constants and helper functions shared by the generator modules.
// ----------------------------------------------------------------------------
package wsg_pkg;

  // Sizes of the design.
  localparam int unsigned MAX_VOICES_DEF = 8;
  localparam int unsigned VOICE_IDX_W    = 3;
  localparam int unsigned CNT_W          = 4;
  localparam int unsigned CFG_W          = 4;
  localparam int unsigned SUM_W          = 16;
  localparam int unsigned FREQ_W         = 20;
  localparam int unsigned PHASE_W        = 32;
  localparam int unsigned MULT_W         = 12;
  localparam int unsigned SLOT_W         = 3;
  localparam int unsigned DIV_CNT_W      = $clog2(SUM_W);

  // Frequency to phase step factors of the two register layouts.
  localparam logic [MULT_W-1:0] STEP_MUL_3V = 12'd2177;
  localparam logic [MULT_W-1:0] STEP_MUL_8B = 12'd544;

  // Last register fetch slot of each layout.
  localparam logic [SLOT_W-1:0] SLOT_LAST_3V = 3'd6;
  localparam logic [SLOT_W-1:0] SLOT_LAST_8B = 3'd3;

  // Configuration register indexes.
  localparam logic CFG_VOICE_COUNT  = 1'b0;
  localparam logic CFG_SOUND_ENABLE = 1'b1;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_REG_WRITE = 2'd0,
    OP_REG_READ  = 2'd1,
    OP_TICK      = 2'd2,
    OP_WAVE_LOAD = 2'd3
  } wsg_op_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] address;
    logic [7:0] write_data;
  } wsg_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [14:0] sample_out;
  } wsg_result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                   reg_wr;
    logic                   reg_rd;
    logic                   wave_wr;
    logic                   fetch;
    logic [5:0]             fetch_addr;
    logic                   cap;
    logic [SLOT_W-1:0]      cap_slot;
    logic                   layout3;
    logic                   first_voice;
    logic [VOICE_IDX_W-1:0] voice;
    logic [CNT_W-1:0]       n;
    logic                   sum_clear;
    logic                   step_calc;
    logic                   accum;
    logic                   div_load;
    logic                   div_step;
    logic                   res_zero;
    logic                   res_read;
    logic                   res_sample;
  } wsg_cmd_t;

  // Register address of one fetch slot of a voice.
  function automatic logic [5:0] reg_addr(input logic                   layout3,
                                          input logic [VOICE_IDX_W-1:0] voice,
                                          input logic [SLOT_W-1:0]      slot);
    logic [5:0] base;
    logic [5:0] addr;
    if (layout3) begin
      // Three-voice layout: five registers apart per voice.
      base = {1'b0, voice, 2'b00} + {3'b000, voice};
      if (slot == 3'd0) begin
        addr = 6'h10;
      end else if (slot == SLOT_LAST_3V) begin
        addr = 6'h05 + base;
      end else begin
        addr = 6'h10 + {3'b000, slot} + base;
      end
    end else begin
      // Eight-byte layout starting at offset three.
      base = {voice, 3'b000} + 6'd3;
      addr = base + {3'b000, slot};
    end
    return addr;
  endfunction

endpackage

@@ rtl/wsg_ctrl.sv @@
// ----------------------------------------------------------------------------
// Wavetable sound generator controller
// State machine that sequences register fetches, voice mixing and division.
// ----------------------------------------------------------------------------
`include "wavetable_sound_generator_defines.svh"

module wsg_ctrl #(
  parameter int unsigned MAX_VOICES = wsg_pkg::MAX_VOICES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [1:0]                op_i,
  input  logic                      enable_i,
  input  logic [wsg_pkg::CNT_W-1:0] n_i,
  output logic                      busy_o,
  output logic                      done_o,
  output wsg_pkg::wsg_cmd_t         cmd_o
);
  import wsg_pkg::*;

  localparam int unsigned VW = $clog2(MAX_VOICES);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_RD    = 9'b000000010,
    ST_FETCH = 9'b000000100,
    ST_WAITB = 9'b000001000,
    ST_STEP  = 9'b000010000,
    ST_ACC   = 9'b000100000,
    ST_DIVLD = 9'b001000000,
    ST_DIV   = 9'b010000000,
    ST_FIN   = 9'b100000000
  } state_e;

  state_e                state_q, state_d;
  logic [VW-1:0]         voice_q, voice_d;
  logic [SLOT_W-1:0]     slot_q, slot_d;
  logic [DIV_CNT_W-1:0]  div_cnt_q, div_cnt_d;
  logic                  cap_q;
  logic [SLOT_W-1:0]     cap_slot_q;
  logic                  done_q, done_d;
  logic                  layout3;
  logic [SLOT_W-1:0]     slot_last;
  logic                  last_voice;

  // Layout selection and voice loop bounds.
  assign layout3    = (n_i == 4'd3);
  assign slot_last  = layout3 ? SLOT_LAST_3V : SLOT_LAST_8B;
  assign last_voice = (CNT_W'(voice_q) == (n_i - 4'd1));

  // Next state and command decode.
  always_comb begin
    state_d            = state_q;
    voice_d            = voice_q;
    slot_d             = slot_q;
    div_cnt_d          = div_cnt_q;
    done_d             = 1'b0;
    cmd_o              = '0;
    cmd_o.layout3      = layout3;
    cmd_o.n            = n_i;
    cmd_o.voice        = VOICE_IDX_W'(voice_q);
    cmd_o.first_voice  = (voice_q == '0);
    cmd_o.cap          = cap_q;
    cmd_o.cap_slot     = cap_slot_q;
    cmd_o.fetch_addr   = reg_addr(layout3, VOICE_IDX_W'(voice_q), slot_q);
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (op_i)
            OP_REG_WRITE: begin
              cmd_o.reg_wr   = 1'b1;
              cmd_o.res_zero = 1'b1;
              done_d         = 1'b1;
            end
            OP_REG_READ: begin
              cmd_o.reg_rd = 1'b1;
              state_d      = ST_RD;
            end
            OP_TICK: begin
              if (enable_i) begin
                cmd_o.sum_clear = 1'b1;
                voice_d         = '0;
                slot_d          = '0;
                state_d         = ST_FETCH;
              end else begin
                cmd_o.res_zero = 1'b1;
                done_d         = 1'b1;
              end
            end
            OP_WAVE_LOAD: begin
              cmd_o.wave_wr  = 1'b1;
              cmd_o.res_zero = 1'b1;
              done_d         = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        cmd_o.res_read = 1'b1;
        done_d         = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        slot_d      = slot_q + 1'b1;
        if (slot_q == slot_last) begin
          state_d = ST_WAITB;
        end
      end
      ST_WAITB: begin
        state_d = ST_STEP;
      end
      ST_STEP: begin
        cmd_o.step_calc = 1'b1;
        state_d         = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.accum = 1'b1;
        if (last_voice) begin
          state_d = ST_DIVLD;
        end else begin
          voice_d = voice_q + 1'b1;
          slot_d  = '0;
          state_d = ST_FETCH;
        end
      end
      ST_DIVLD: begin
        cmd_o.div_load = 1'b1;
        div_cnt_d      = '1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        div_cnt_d      = div_cnt_q - 1'b1;
        if (div_cnt_q == '0) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.res_sample = 1'b1;
        done_d           = 1'b1;
        state_d          = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      voice_q    <= '0;
      slot_q     <= '0;
      div_cnt_q  <= '0;
      cap_q      <= 1'b0;
      cap_slot_q <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      voice_q    <= voice_d;
      slot_q     <= slot_d;
      div_cnt_q  <= div_cnt_d;
      cap_q      <= cmd_o.fetch;
      cap_slot_q <= slot_q;
      done_q     <= done_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

  // A fetch never runs past the last slot of the layout.
  `WSG_NEVER(a_slot_in_range, (state_q == ST_FETCH) && (slot_q > slot_last), "slot overrun")
  // The voice counter stays below the active voice count.
  `WSG_NEVER(a_voice_in_range, (state_q == ST_FETCH) && (CNT_W'(voice_q) >= n_i), "voice overrun")
  // A captured byte only arrives while fetching or in the byte wait state.
  `WSG_ASSERT(a_cap_state, cap_q |-> (state_q == ST_FETCH || state_q == ST_WAITB), "stray capture")
  // The mixed sample is strobed right after the final state.
  `WSG_ASSERT(a_fin_done, (state_q == ST_FIN) |=> done_q, "missing sample strobe")

endmodule

@@ rtl/wsg_datapath.sv @@
// ----------------------------------------------------------------------------
// Wavetable sound generator datapath
// Register file, wave table, voice phases, mixer and sample divider.
// ----------------------------------------------------------------------------
module wsg_datapath #(
  parameter int unsigned MAX_VOICES = wsg_pkg::MAX_VOICES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wsg_pkg::wsg_item_t    item_i,
  input  wsg_pkg::wsg_cmd_t     cmd_i,
  output wsg_pkg::wsg_result_t  result_o
);
  import wsg_pkg::*;

  localparam int unsigned VW = $clog2(MAX_VOICES);

  // Sound register file with valid bits for the all-zero reset value.
  logic [7:0]              reg_mem [64];
  logic [63:0]             reg_valid_q;
  logic [5:0]              rd_addr;
  logic [7:0]              rdata_q;
  logic                    rvalid_q;
  logic [7:0]              rbyte;

  // Wave table with valid bits.
  logic [3:0]              wave_mem [256];
  logic [255:0]            wave_valid_q;
  logic [7:0]              widx;
  logic [3:0]              wdata_q;
  logic                    wvalid_q;
  logic [3:0]              nibble;

  // Voice decode and mixing state.
  logic [PHASE_W-1:0]      phase_q [MAX_VOICES];
  logic [VW-1:0]           vidx;
  logic [FREQ_W-1:0]       freq_q;
  logic [2:0]              vol_q;
  logic [2:0]              wave_q;
  logic [PHASE_W-1:0]      step_q;
  logic [MULT_W-1:0]       mult;
  logic [PHASE_W-1:0]      prod;
  logic                    active;
  logic [6:0]              term;
  logic [SUM_W-1:0]        sum_q;

  // Divider state.
  logic [SUM_W-1:0]        quo_q;
  logic [CNT_W-1:0]        rem_q;
  logic [CNT_W:0]          rem_sh;
  logic                    rem_ge;
  logic [CNT_W:0]          rem_sub;
  logic [14:0]             sample;

  wsg_result_t             result_q;

  assign vidx = cmd_i.voice[VW-1:0];

  // Register file port: writes from items, reads for items or voice fetches.
  assign rd_addr = cmd_i.reg_rd ? item_i.address[5:0] : cmd_i.fetch_addr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.reg_wr) begin
      reg_mem[item_i.address[5:0]] <= item_i.write_data;
    end
    rdata_q <= reg_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_valid_q <= '0;
      rvalid_q    <= 1'b0;
    end else begin
      if (cmd_i.reg_wr) begin
        reg_valid_q[item_i.address[5:0]] <= 1'b1;
      end
      rvalid_q <= reg_valid_q[rd_addr];
    end
  end

  assign rbyte = rvalid_q ? rdata_q : 8'h00;

  // Wave table port: loads keep the low nibble; reads index by wave and phase.
  assign widx = {wave_q, phase_q[vidx][29:25]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.wave_wr) begin
      wave_mem[item_i.address] <= item_i.write_data[3:0];
    end
    wdata_q <= wave_mem[widx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_valid_q <= '0;
      wvalid_q     <= 1'b0;
    end else begin
      if (cmd_i.wave_wr) begin
        wave_valid_q[item_i.address] <= 1'b1;
      end
      wvalid_q <= wave_valid_q[widx];
    end
  end

  assign nibble = wvalid_q ? wdata_q : 4'h0;

  // Collect the voice fields as the fetched bytes arrive.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      if (cmd_i.layout3) begin
        case (cmd_i.cap_slot)
          3'd0: freq_q[3:0]   <= cmd_i.first_voice ? rbyte[3:0] : 4'h0;
          3'd1: freq_q[7:4]   <= rbyte[3:0];
          3'd2: freq_q[11:8]  <= rbyte[3:0];
          3'd3: freq_q[15:12] <= rbyte[3:0];
          3'd4: freq_q[19:16] <= rbyte[3:0];
          3'd5: vol_q         <= rbyte[3:1];
          3'd6: wave_q        <= rbyte[2:0];
          default: ;
        endcase
      end else begin
        case (cmd_i.cap_slot)
          3'd0: vol_q        <= rbyte[3:1];
          3'd1: freq_q[7:0]  <= rbyte;
          3'd2: freq_q[15:8] <= rbyte;
          3'd3: begin
            freq_q[19:16] <= rbyte[3:0];
            wave_q        <= rbyte[6:4];
          end
          default: ;
        endcase
      end
    end
  end

  // Phase step, registered before it feeds the phase adder.
  assign mult = cmd_i.layout3 ? STEP_MUL_3V : STEP_MUL_8B;
  assign prod = PHASE_W'(freq_q) * PHASE_W'(mult);

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_calc) begin
      step_q <= prod;
    end
  end

  // A voice plays unless its step or volume rules it out for the layout.
  assign active = cmd_i.layout3 ? ((step_q != '0) && (vol_q != 3'd0))
                                : ((step_q != '0) || (vol_q != 3'd0));
  assign term   = 7'(nibble) * 7'(vol_q);

  // Mix accumulator.
  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_clear) begin
      sum_q <= '0;
    end else if (cmd_i.accum && active) begin
      sum_q <= sum_q + SUM_W'({term, 6'b000000});
    end
  end

  // Voice phases: advance when active, clear when not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_VOICES; i++) begin
        phase_q[i] <= '0;
      end
    end else if (cmd_i.accum) begin
      phase_q[vidx] <= active ? (phase_q[vidx] + step_q) : '0;
    end
  end

  // Restoring divider by the voice count, one quotient bit per cycle.
  assign rem_sh  = {rem_q, quo_q[SUM_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, cmd_i.n});
  assign rem_sub = rem_sh - {1'b0, cmd_i.n};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      quo_q <= sum_q;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[SUM_W-2:0], rem_ge};
      rem_q <= rem_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
  end

  // Quotient times four, saturated to the sample range.
  assign sample = (quo_q[SUM_W-1:13] != '0) ? 15'h7fff : {quo_q[12:0], 2'b00};

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_zero) begin
      result_q <= '0;
    end else if (cmd_i.res_read) begin
      result_q.read_data  <= rbyte;
      result_q.sample_out <= '0;
    end else if (cmd_i.res_sample) begin
      result_q.read_data  <= '0;
      result_q.sample_out <= sample;
    end
  end

  assign result_o = result_q;

endmodule

@@ rtl/wavetable_sound_generator.sv @@
// ----------------------------------------------------------------------------
// Wavetable sound generator
// Multi-voice wavetable sound chip with a register file and a wave table.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low, and its one result
// appears on result_o for the single cycle in which done_o is high; the
// receiver must take it then. Register writes and wave table loads, and ticks
// while sound is disabled, give their result in the next cycle and leave the
// block free to take the next item at once. A register read keeps the block
// busy while it passes through a read state, and gives its result later than
// a write. An enabled tick keeps it busy while it fetches each active voice's
// register bytes (seven in the three-voice layout, four in the eight-byte
// layout) and then divides the mix of the voices by the voice count. That
// busy time is set by the single read port of the register file, one byte
// per cycle, and by the sixteen-step divider. Configuration must be written
// only while idle; the block itself does not enforce it.
module wavetable_sound_generator #(
  parameter int unsigned MAX_VOICES = wsg_pkg::MAX_VOICES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  wsg_pkg::wsg_item_t        item_i,
  output logic                      busy_o,
  output logic                      done_o,
  output wsg_pkg::wsg_result_t      result_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [wsg_pkg::CFG_W-1:0] cfg_wdata_i
);
  import wsg_pkg::*;

  logic [CNT_W-1:0] voice_count_q;
  logic             sound_enable_q;
  logic [CNT_W-1:0] n_eff;
  wsg_cmd_t         cmd;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voice_count_q  <= 4'd3;
      sound_enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_VOICE_COUNT:  voice_count_q  <= cfg_wdata_i;
        CFG_SOUND_ENABLE: sound_enable_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Voice count clamped to one through the voice limit.
  always_comb begin
    if (voice_count_q == '0) begin
      n_eff = 4'd1;
    end else if (voice_count_q > CNT_W'(MAX_VOICES)) begin
      n_eff = CNT_W'(MAX_VOICES);
    end else begin
      n_eff = voice_count_q;
    end
  end

  // Controller.
  wsg_ctrl #(
    .MAX_VOICES (MAX_VOICES)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .op_i     (item_i.operation),
    .enable_i (sound_enable_q),
    .n_i      (n_eff),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .cmd_o    (cmd)
  );

  // Datapath.
  wsg_datapath #(
    .MAX_VOICES (MAX_VOICES)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .result_o (result_o)
  );

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// Wavetable sound generator testbench
// Drives register writes, register reads, wave table loads and sample ticks
// through the command port under several voice counts and enable settings.
// Every returned result is checked field by field against a built-in
// prediction of the register file, the wave table and the voice phases.
// ----------------------------------------------------------------------------
module testbench;
  import wsg_pkg::*;

  localparam int unsigned VOICES          = MAX_VOICES_DEF;
  localparam int unsigned NUM_PHASES      = 10;
  localparam int unsigned ITEMS_PER_PHASE = 55;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned TAIL_CYCLES     = 100;
  localparam int unsigned CYCLE_LIMIT     = 400000;

  // Voice count and enable value written at the start of each phase.
  localparam logic [NUM_PHASES-1:0][CFG_W-1:0] PHASE_COUNT =
    {4'd3, 4'd6, 4'd8, 4'd2, 4'd5, 4'd15, 4'd0, 4'd1, 4'd8, 4'd3};
  localparam logic [NUM_PHASES-1:0][CFG_W-1:0] PHASE_ENABLE =
    {4'd1, 4'd1, 4'd0, 4'd1, 4'd14, 4'd1, 4'd1, 4'd15, 4'd1, 4'd1};

  typedef enum logic [1:0] {
    JOB_ITEM,
    JOB_CFG,
    JOB_DRAIN
  } job_kind_e;

  typedef struct {
    job_kind_e        kind;
    wsg_item_t        item;
    int unsigned      gap;
    logic             cfg_idx;
    logic [CFG_W-1:0] cfg_data;
  } sound_job_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start_i     = 1'b0;
  wsg_item_t        item_i      = '0;
  logic             busy_o;
  logic             done_o;
  wsg_result_t      result_o;
  logic             cfg_we_i    = 1'b0;
  logic             cfg_idx_i   = CFG_VOICE_COUNT;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  // Predicted state of the block.
  logic [7:0]       snd_regs  [64];
  logic [31:0]      phase_acc [VOICES];
  logic [3:0]       wave_mem  [256];
  logic [CFG_W-1:0] voice_cnt = 4'd3;
  logic             snd_on    = 1'b1;

  sound_job_t  job_q[$];
  wsg_result_t expected_q[$];

  logic        took_item   = 1'b0;
  logic        stim_done   = 1'b0;
  int unsigned wait_cnt    = 0;
  int unsigned burst_left  = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches  = 0;

  wavetable_sound_generator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .item_i      (item_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Apply one item to the predicted state and return its expected result.
  function automatic wsg_result_t predict_result(input wsg_item_t it);
    wsg_result_t res;
    int unsigned n;
    int unsigned b;
    logic [31:0] sum;
    logic [31:0] freq;
    logic [31:0] step;
    logic [3:0]  wave;
    logic [2:0]  vol;
    logic [7:0]  idx;
    logic        active;
    res = '0;
    case (it.operation)
      OP_REG_WRITE: snd_regs[it.address[5:0]] = it.write_data;
      OP_REG_READ:  res.read_data = snd_regs[it.address[5:0]];
      OP_WAVE_LOAD: wave_mem[it.address] = it.write_data[3:0];
      OP_TICK: begin
        if (snd_on) begin
          n = voice_cnt;
          if (n < 1) n = 1;
          if (n > VOICES) n = VOICES;
          sum = '0;
          for (int v = 0; v < n; v++) begin
            if (n == 3) begin
              // Three-voice layout: nibble-wide frequency digits, 5 bytes apart.
              b    = 5 * v;
              wave = {1'b0, snd_regs[('h05 + b) % 64][2:0]};
              vol  = snd_regs[('h15 + b) % 64][3:1];
              freq = {12'd0, snd_regs[('h14 + b) % 64][3:0], snd_regs[('h13 + b) % 64][3:0],
                      snd_regs[('h12 + b) % 64][3:0], snd_regs[('h11 + b) % 64][3:0], 4'd0};
              if (v == 0) freq[3:0] = snd_regs[6'h10][3:0];
              step   = freq * 32'(STEP_MUL_3V);
              active = (step != 0) && (vol != 0);
            end else begin
              // Eight-byte layout: one volume byte and a 20-bit frequency.
              b    = 8 * v + 3;
              wave = snd_regs[(b + 3) % 64][7:4];
              vol  = snd_regs[b % 64][3:1];
              freq = {12'd0, snd_regs[(b + 3) % 64][3:0], snd_regs[(b + 2) % 64],
                      snd_regs[(b + 1) % 64]};
              step   = freq * 32'(STEP_MUL_8B);
              active = (step != 0) || (vol != 0);
            end
            if (!active) begin
              phase_acc[v] = '0;
            end else begin
              // The table index wraps within 256 entries.
              idx          = {wave[2:0], phase_acc[v][29:25]};
              sum          = sum + ((32'(wave_mem[idx]) * 32'(vol)) << 6);
              phase_acc[v] = phase_acc[v] + step;
            end
          end
          sum = (sum / n) * 4;
          if (sum > 32767) sum = 32767;
          res.sample_out = sum[14:0];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Queue one item, with a random wait in front of it or none inside a burst.
  function automatic void add_item(input wsg_op_e op, input logic [7:0] addr,
                                   input logic [7:0] data);
    sound_job_t j;
    j.kind     = JOB_ITEM;
    j.item     = '{operation: op, address: addr, write_data: data};
    j.cfg_idx  = CFG_VOICE_COUNT;
    j.cfg_data = '0;
    if (burst_left != 0) begin
      burst_left--;
      j.gap = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(10, 40);
      j.gap      = 0;
    end else begin
      j.gap = $urandom_range(0, 19);
    end
    job_q.push_back(j);
  endfunction

  // Queue a configuration write; the driver holds it until the block is idle.
  function automatic void add_cfg(input logic idx, input logic [CFG_W-1:0] data);
    sound_job_t j;
    j.kind     = JOB_CFG;
    j.item     = '0;
    j.gap      = 0;
    j.cfg_idx  = idx;
    j.cfg_data = data;
    job_q.push_back(j);
  endfunction

  // Stimulus: directed items, then phases of random items per configuration.
  initial begin
    int unsigned n_eff;
    int unsigned v;
    int unsigned sel;
    sound_job_t  hold;
    foreach (snd_regs[i]) snd_regs[i] = '0;
    foreach (phase_acc[i]) phase_acc[i] = '0;
    foreach (wave_mem[i]) wave_mem[i] = '0;

    // Directed part in the reset configuration of three voices.
    add_item(OP_TICK, 8'h00, 8'h00);
    add_item(OP_WAVE_LOAD, 8'h00, 8'hff);
    add_item(OP_WAVE_LOAD, 8'hff, 8'ha5);
    add_item(OP_WAVE_LOAD, 8'h20, 8'h37);
    add_item(OP_REG_WRITE, 8'h00, 8'hff);
    add_item(OP_REG_READ, 8'h00, 8'h00);
    add_item(OP_REG_WRITE, 8'hff, 8'h5a);
    add_item(OP_REG_READ, 8'h3f, 8'hff);
    add_item(OP_REG_READ, 8'hbf, 8'h00);
    // Voice 0 at full volume with a step large enough to wrap the phase.
    add_item(OP_REG_WRITE, 8'h10, 8'h0f);
    add_item(OP_REG_WRITE, 8'h11, 8'hff);
    add_item(OP_REG_WRITE, 8'h14, 8'hff);
    add_item(OP_REG_WRITE, 8'h15, 8'h0f);
    // Voice 1 on wave 1; voice 2 has a frequency but zero volume.
    add_item(OP_REG_WRITE, 8'h1a, 8'h0e);
    add_item(OP_REG_WRITE, 8'h16, 8'h01);
    add_item(OP_REG_WRITE, 8'h0a, 8'h01);
    add_item(OP_REG_WRITE, 8'h1b, 8'h08);
    add_item(OP_REG_WRITE, 8'h1f, 8'h01);
    repeat (5) add_item(OP_TICK, 8'h00, 8'h00);
    add_item(OP_REG_READ, 8'h15, 8'h00);

    for (int p = 0; p < NUM_PHASES; p++) begin
      add_cfg(CFG_VOICE_COUNT, PHASE_COUNT[p]);
      add_cfg(CFG_SOUND_ENABLE, PHASE_ENABLE[p]);
      n_eff = (PHASE_COUNT[p] == 0) ? 1 :
              ((PHASE_COUNT[p] > VOICES) ? VOICES : PHASE_COUNT[p]);
      // Twice, fill in the registers of a randomly chosen voice of the current layout.
      repeat (2) begin
        v = $urandom_range(0, n_eff - 1);
        if (n_eff == 3) begin
          add_item(OP_REG_WRITE, 8'(8'h05 + 5 * v), 8'($urandom_range(0, 255)));
          for (int r = 1; r <= 5; r++) begin
            add_item(OP_REG_WRITE, 8'(8'h10 + r + 5 * v), 8'($urandom_range(0, 255)));
          end
        end else begin
          for (int r = 0; r < 4; r++) begin
            add_item(OP_REG_WRITE, 8'(8 * v + 3 + r), 8'($urandom_range(0, 255)));
          end
        end
      end
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // Now and then stop sending until every result is back.
        if (k == ITEMS_PER_PHASE / 2 && p[0]) begin
          hold.kind     = JOB_DRAIN;
          hold.item     = '0;
          hold.gap      = 0;
          hold.cfg_idx  = CFG_VOICE_COUNT;
          hold.cfg_data = '0;
          job_q.push_back(hold);
        end
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
          add_item(OP_REG_WRITE, 8'($urandom_range(0, 255)),
                   ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
        end else if (sel < 50) begin
          add_item(OP_REG_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end else if (sel < 80) begin
          add_item(OP_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end else begin
          add_item(OP_WAVE_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the driver to run dry and for every result to come back.
    wait (stim_done);
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Driver: presents items and configuration writes at the falling edge.
  always @(negedge clk_i) begin : drive_items
    logic nxt_start;
    logic nxt_we;
    nxt_start = start_i && !took_item;
    nxt_we    = 1'b0;
    if (rst_ni && !nxt_start) begin
      if (job_q.size() == 0) begin
        stim_done <= 1'b1;
      end else if (job_q[0].kind == JOB_ITEM) begin
        if (wait_cnt < job_q[0].gap) begin
          wait_cnt++;
        end else begin
          item_i    <= job_q[0].item;
          nxt_start = 1'b1;
          wait_cnt  = 0;
          void'(job_q.pop_front());
        end
      end else if (expected_q.size() != 0) begin
        wait_cnt = 0;
      end else if (wait_cnt < SETTLE_CYCLES) begin
        wait_cnt++;
      end else begin
        // The block has been idle for a while; safe to reconfigure.
        if (job_q[0].kind == JOB_CFG) begin
          cfg_idx_i   <= job_q[0].cfg_idx;
          cfg_wdata_i <= job_q[0].cfg_data;
          nxt_we      = 1'b1;
        end
        wait_cnt = 0;
        void'(job_q.pop_front());
      end
    end
    start_i  <= nxt_start;
    cfg_we_i <= nxt_we;
  end

  // Monitor: checks results, predicts accepted items, tracks configuration.
  always @(posedge clk_i) begin : check_results
    wsg_result_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h, nothing pending", $time, result_o);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (result_o.read_data !== want.read_data) begin
            $display("%0t: read_data mismatch, expected %h, got %h",
                     $time, want.read_data, result_o.read_data);
            mismatches++;
          end
          if (result_o.sample_out !== want.sample_out) begin
            $display("%0t: sample_out mismatch, expected %0d, got %0d",
                     $time, want.sample_out, result_o.sample_out);
            mismatches++;
          end
        end
      end
      if (start_i && !busy_o) expected_q.push_back(predict_result(item_i));
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_VOICE_COUNT) begin
          voice_cnt = cfg_wdata_i;
        end else begin
          snd_on = cfg_wdata_i[0];
        end
      end
    end
    took_item <= rst_ni && start_i && !busy_o;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

endmodule
